// File: src/b64enc_pkg.sv
package b64enc_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] PAD_CHAR = 8'h3D;
   localparam logic [5:0] SEXTET_MASK = 6'h3F;

   localparam logic [1:0] POS_EMPTY = 2'd0;
   localparam logic [1:0] POS_ONE = 2'd1;
   localparam logic [1:0] POS_TWO = 2'd2;

   localparam logic [1:0] CHAR_FIRST = 2'd0;
   localparam logic [1:0] CHAR_SECOND = 2'd1;
   localparam logic [1:0] CHAR_THIRD = 2'd2;
   localparam logic [1:0] CHAR_FOURTH = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_char;
   } rsp_type;

   typedef struct packed {
      logic [23:0] word;
      logic [1:0]  byte_count;
      logic        final_group;
   } group_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] value);
      logic [7:0] v8;
      logic [7:0] result;
      v8 = {2'b00, value & SEXTET_MASK};
      if (v8 < 8'd26) begin
         result = 8'h41 + v8;
      end else if (v8 < 8'd52) begin
         result = 8'h61 + (v8 - 8'd26);
      end else if (v8 < 8'd62) begin
         result = 8'h30 + (v8 - 8'd52);
      end else if (v8 == 8'd62) begin
         result = 8'h2B;
      end else begin
         result = 8'h2F;
      end
      return result;
   endfunction

endpackage

// File: src/b64enc_queue.sv
module b64enc_queue #(
   parameter int Depth = b64enc_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b64enc_pkg::group_type push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output b64enc_pkg::group_type head
);

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);

   b64enc_pkg::group_type entries_ff [Depth];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   logic do_push;
   logic do_pop;

   assign full      = (count_ff == CW'(Depth));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/b64enc_front.sv
module b64enc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  b64enc_pkg::req_type   req_data,
   output logic                  push,
   output b64enc_pkg::group_type push_data,
   input  logic                  queue_full
);

   logic [15:0] held_ff, held_in;
   logic [1:0]  pos_ff, pos_in;
   logic [1:0]  pos;
   logic        accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign pos       = (pos_ff == b64enc_pkg::POS_TWO) ? b64enc_pkg::POS_TWO :
                      (pos_ff == b64enc_pkg::POS_ONE) ? b64enc_pkg::POS_ONE :
                      b64enc_pkg::POS_EMPTY;

   always_comb begin
      held_in   = held_ff;
      pos_in    = pos_ff;
      push      = 1'b0;
      push_data = '0;
      if (accept) begin
         if (pos == b64enc_pkg::POS_TWO) begin
            push                  = 1'b1;
            push_data.word        = {held_ff, req_data.data_byte};
            push_data.byte_count  = 2'd3;
            push_data.final_group = req_data.final_byte;
            held_in               = '0;
            pos_in                = b64enc_pkg::POS_EMPTY;
         end else if (req_data.final_byte) begin
            push                  = 1'b1;
            push_data.final_group = 1'b1;
            if (pos == b64enc_pkg::POS_ONE) begin
               push_data.word       = {held_ff[15:8], req_data.data_byte, 8'h00};
               push_data.byte_count = 2'd2;
            end else begin
               push_data.word       = {req_data.data_byte, 16'h0000};
               push_data.byte_count = 2'd1;
            end
            held_in = '0;
            pos_in  = b64enc_pkg::POS_EMPTY;
         end else begin
            if (pos == b64enc_pkg::POS_ONE) begin
               held_in = {held_ff[15:8], req_data.data_byte};
               pos_in  = b64enc_pkg::POS_TWO;
            end else begin
               held_in = {req_data.data_byte, 8'h00};
               pos_in  = b64enc_pkg::POS_ONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         pos_ff  <= b64enc_pkg::POS_EMPTY;
      end else begin
         held_ff <= held_in;
         pos_ff  <= pos_in;
      end
   end

endmodule

// File: src/b64enc_back.sv
module b64enc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_not_empty,
   input  b64enc_pkg::group_type queue_head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output b64enc_pkg::rsp_type   rsp_data
);

   b64enc_pkg::group_type grp_ff, grp_in;
   logic                  busy_ff, busy_in;
   logic [1:0]            idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   b64enc_pkg::rsp_type   rsp_ff, rsp_in;

   logic       load;
   logic       done;
   logic [7:0] next_char;

   assign load      = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign done      = load && (idx_ff == b64enc_pkg::CHAR_FOURTH);
   assign pop       = queue_not_empty && (!busy_ff || done);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      case (idx_ff)
         b64enc_pkg::CHAR_FIRST:  next_char = b64enc_pkg::sextet_char(grp_ff.word[23:18]);
         b64enc_pkg::CHAR_SECOND: next_char = b64enc_pkg::sextet_char(grp_ff.word[17:12]);
         b64enc_pkg::CHAR_THIRD:
            next_char = (grp_ff.byte_count >= 2'd2) ?
                        b64enc_pkg::sextet_char(grp_ff.word[11:6]) : b64enc_pkg::PAD_CHAR;
         b64enc_pkg::CHAR_FOURTH:
            next_char = (grp_ff.byte_count >= 2'd3) ?
                        b64enc_pkg::sextet_char(grp_ff.word[5:0]) : b64enc_pkg::PAD_CHAR;
         default: next_char = b64enc_pkg::PAD_CHAR;
      endcase
   end

   always_comb begin
      grp_in       = grp_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in     = 1'b1;
         rsp_in.out_char  = next_char;
         rsp_in.last_char = (idx_ff == b64enc_pkg::CHAR_FOURTH) && grp_ff.final_group;
         idx_in           = idx_ff + 1'b1;
      end
      if (done) begin
         busy_in = 1'b0;
      end
      if (pop) begin
         grp_in  = queue_head;
         busy_in = 1'b1;
         idx_in  = b64enc_pkg::CHAR_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= b64enc_pkg::CHAR_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
      rsp_ff <= rsp_in;
   end

endmodule

// File: src/base64_encoder.sv
// Base64 encoder, standard alphabet with '=' padding.
// Input channel (req_*): one raw byte per transfer, final_byte marks the last
// byte of a message. Result channel (rsp_*): one ASCII character per transfer;
// last_char is set on the fourth character of the message's final group.
// Every third byte of a group, or a final byte, yields four characters; a
// partial final group ends in "=" or "==". A message of no bytes yields none.
// The byte that completes a group is written into the group queue; the group
// then moves into the serializer register and its first character into the
// output register. Throughput is set by the output serializer, one character
// per cycle while the receiver does not stall. Bytes that only fill a group
// are taken every cycle while the group queue has room.
// A stalled receiver holds the output register; the serializer and then the
// group queue fill, after which req_stall rises. The grouping front keeps
// taking bytes that do not complete a group until the queue is full.
// Reset (synchronous) empties the queue, drops any pending partial group and
// any undelivered character.
module base64_encoder #(
   parameter int QueueDepth = b64enc_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  b64enc_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output b64enc_pkg::rsp_type rsp_data
);

   logic                  push;
   b64enc_pkg::group_type push_data;
   logic                  queue_full;
   logic                  pop;
   logic                  queue_not_empty;
   b64enc_pkg::group_type queue_head;

   b64enc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   b64enc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .head      (queue_head)
   );

   b64enc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_head      (queue_head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data)
   );

endmodule

// File: tb/sv/base64_checker.sv
module base64_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  b64enc_pkg::req_type req_data,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  b64enc_pkg::rsp_type rsp_data,
   output int                  fail_count,
   output int                  pending_chars
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [511:0] B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   b64enc_pkg::rsp_type expected_chars[$];
   logic [15:0]         held_pair;
   logic [1:0]          held_count;

   function automatic logic [7:0] sextet_to_ascii(input logic [5:0] value);
      return B64_ALPHABET[8*(63 - int'(value)) +: 8];
   endfunction

   task automatic encode_byte(input b64enc_pkg::req_type item);
      logic [23:0]         group_bits;
      int                  byte_count;
      logic                do_emit;
      b64enc_pkg::rsp_type ch;
      group_bits = '0;
      byte_count = 0;
      do_emit    = 1'b1;
      case (held_count)
         b64enc_pkg::POS_TWO: begin
            group_bits = {held_pair, item.data_byte};
            byte_count = 3;
         end
         b64enc_pkg::POS_ONE: begin
            if (item.final_byte) begin
               group_bits = {held_pair[15:8], item.data_byte, 8'h00};
               byte_count = 2;
            end else begin
               held_pair[7:0] = item.data_byte;
               held_count     = b64enc_pkg::POS_TWO;
               do_emit        = 1'b0;
            end
         end
         default: begin
            if (item.final_byte) begin
               group_bits = {item.data_byte, 16'h0000};
               byte_count = 1;
            end else begin
               held_pair  = {item.data_byte, 8'h00};
               held_count = b64enc_pkg::POS_ONE;
               do_emit    = 1'b0;
            end
         end
      endcase
      if (do_emit) begin
         ch.last_char = 1'b0;
         ch.out_char  = sextet_to_ascii(group_bits[23:18]);
         expected_chars = {expected_chars, ch};
         ch.out_char  = sextet_to_ascii(group_bits[17:12]);
         expected_chars = {expected_chars, ch};
         ch.out_char  = (byte_count >= 2) ? sextet_to_ascii(group_bits[11:6]) :
                        b64enc_pkg::PAD_CHAR;
         expected_chars = {expected_chars, ch};
         ch.out_char  = (byte_count >= 3) ? sextet_to_ascii(group_bits[5:0]) :
                        b64enc_pkg::PAD_CHAR;
         ch.last_char = item.final_byte;
         expected_chars = {expected_chars, ch};
         held_pair  = '0;
         held_count = b64enc_pkg::POS_EMPTY;
      end
   endtask

   always @(posedge clock) begin
      b64enc_pkg::rsp_type want;
      if (reset) begin
         held_pair  = '0;
         held_count = b64enc_pkg::POS_EMPTY;
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            encode_byte(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected char %h last %b", $time,
                        rsp_data.out_char, rsp_data.last_char);
               fail_count = fail_count + 1;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.out_char !== want.out_char) begin
                  $display("%0t: out_char expected %h actual %h", $time,
                           want.out_char, rsp_data.out_char);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.last_char !== want.last_char) begin
                  $display("%0t: last_char expected %b actual %b", $time,
                           want.last_char, rsp_data.last_char);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
      pending_chars = expected_chars.size();
   end

endmodule

// File: tb/sv/tb_base64_encoder.sv
module tb_base64_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_BYTES = 27;
   localparam int HOLD_OFF_CYCLES = 80;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   b64enc_pkg::req_type req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   b64enc_pkg::rsp_type rsp_data;

   int fail_count;
   int pending_chars;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   logic hold_off_req = 1'b0;
   int phase_bytes;

   base64_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   base64_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_chars (pending_chars)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic chance(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // receiver: random stall, or a long hold-off when requested
   initial begin
      int   hold_left;
      logic hold_taken;
      rsp_stall  = 1'b0;
      hold_left  = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_taken) begin
            hold_left  = HOLD_OFF_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left = hold_left - 1;
         end else begin
            rsp_stall = chance(stall_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic last);
      while (chance(send_idle_pct)) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid           = 1'b1;
      req_data.data_byte  = value;
      req_data.final_byte = last;
      do begin
         @(posedge clock);
      end while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(0, 255)), i == len - 1);
      end
      phase_bytes = phase_bytes + len;
   endtask

   task automatic run_phase(input int idle_pct, input int busy_pct);
      int len;
      send_idle_pct = idle_pct;
      stall_pct     = busy_pct;
      phase_bytes   = 0;
      while (phase_bytes < PHASE_BYTES) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 7);
         send_message(len);
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // padded groups, full groups, alphabet extremes
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b1);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hAA, 1'b1);

      // hold off the receiver while the sender keeps going
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_off_req  = 1'b1;
      for (int i = 0; i < 30; i++) begin
         send_byte(8'($urandom_range(0, 255)), i == 29);
      end

      run_phase(0, 0);
      run_phase(87, 0);
      run_phase(0, 87);
      run_phase(14, 14);

      req_valid = 1'b0;
      while (pending_chars != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/b64enc_pkg.sv
src/b64enc_queue.sv
src/b64enc_front.sv
src/b64enc_back.sv
src/base64_encoder.sv
tb/sv/base64_checker.sv
tb/sv/tb_base64_encoder.sv
